FILE: src/fpn_pkg.sv
// Shared widths, codes and helpers of the fixpoint piecewise normalizer.
// No dependencies; used by fpn_div, fpn_mul and the top level.
package fpn_pkg;

    localparam int DATA_W = 32;              // Q16.16 word
    localparam int FRAC_W = 16;
    localparam int DIFF_W = DATA_W + 1;      // exact difference of two words
    localparam int QUO_W  = DIFF_W + FRAC_W; // dividend bits of num * 2^16
    localparam int PROD_W = 2 * DATA_W + 2 - FRAC_W; // floor(d * r / 2^16)
    localparam int SUM_W  = PROD_W + 2;
    localparam int QCNT_W = $clog2(QUO_W);
    localparam int MCNT_W = $clog2(DATA_W);
    localparam int CFG_AW = 4;

    localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sd65536;
    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    // action codes
    localparam logic [1:0] ACT_RESTART = 2'd0;
    localparam logic [1:0] ACT_TRACK   = 2'd1;
    localparam logic [1:0] ACT_FWD     = 2'd2;
    localparam logic [1:0] ACT_BACK    = 2'd3;

    // register indexes
    localparam logic [1:0] REG_PIVOT      = 2'd0;
    localparam logic [1:0] REG_PIVOT_NORM = 2'd1;
    localparam logic [1:0] REG_NORM_LOW   = 2'd2;
    localparam logic [1:0] REG_NORM_HIGH  = 2'd3;

    // exact difference a - b
    function automatic logic signed [DIFF_W-1:0] dif33(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        return $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
    endfunction

    function automatic logic signed [SUM_W-1:0] sext_w(input logic signed [DATA_W-1:0] a);
        return $signed({{(SUM_W-DATA_W){a[DATA_W-1]}}, a});
    endfunction

    function automatic logic signed [SUM_W-1:0] sext_p(input logic signed [PROD_W-1:0] a);
        return $signed({{(SUM_W-PROD_W){a[PROD_W-1]}}, a});
    endfunction

    // saturate a wide sum to a signed word
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic fits;
        fits = (&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]);
        if (fits) begin
            return v[DATA_W-1:0];
        end
        return v[SUM_W-1] ? SAT_MIN : SAT_MAX;
    endfunction

endpackage

FILE: src/fixpoint_piecewise_normalizer.sv
// A track request without last goes straight to the output step; track with last runs the
// 32-step serial multiplier; scale or map back runs the 49-step serial divider, then the multiplier.
// Throughput: one request at a time; the next is taken while a result waits in the
// output register. Reset: synchronous active-low; registers and extremes to defaults.
// Uses fpn_pkg, fpn_div and fpn_mul.
module fixpoint_piecewise_normalizer import fpn_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // sample[31:0]
    input  logic [1:0]        s_tuser,   // action[1:0]
    input  logic              s_tlast,   // last
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [95:0]       m_tdata,   // mapped[31:0], seen_low[63:32], seen_high[95:64]
    output logic [1:0]        m_tuser    // below_norm[0], above_norm[1]
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_SUM   = 3'd4;
    localparam logic [2:0] ST_FIX   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;

    logic signed [DATA_W-1:0] pivot_reg, pnorm_reg, nlow_reg, nhigh_reg;
    logic signed [DATA_W-1:0] min_reg, max_reg;
    logic [1:0]               act_reg;
    logic signed [DATA_W-1:0] samp_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DATA_W-1:0] base_reg;
    logic                     sub_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic                     below_reg, above_reg;

    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_mapped_reg, m_low_reg, m_high_reg;
    logic                     m_below_reg, m_above_reg;

    logic                     cfg_wr, accept, is_track, out_load;
    logic signed [DATA_W-1:0] s_in, bmin, bmax, tmin, tmax;
    logic                     lt;
    logic signed [DIFF_W-1:0] div_num, div_den, sel_diff;
    logic signed [DATA_W-1:0] sel_base;
    logic                     div_start, div_done, mul_start, mul_done;
    logic signed [DATA_W-1:0] div_ratio, mul_r;
    logic signed [DIFF_W-1:0] mul_d;
    logic signed [PROD_W-1:0] mul_prod;
    logic signed [SUM_W-1:0]  exact, fix_hi, fix_lo;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pivot_reg <= '0;
            pnorm_reg <= '0;
            nlow_reg  <= -Q_ONE;
            nhigh_reg <= Q_ONE;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_PIVOT:      pivot_reg <= $signed(pwdata);
                REG_PIVOT_NORM: pnorm_reg <= $signed(pwdata);
                REG_NORM_LOW:   nlow_reg  <= $signed(pwdata);
                REG_NORM_HIGH:  nhigh_reg <= $signed(pwdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PIVOT:      prdata = pivot_reg;
            REG_PIVOT_NORM: prdata = pnorm_reg;
            REG_NORM_LOW:   prdata = nlow_reg;
            REG_NORM_HIGH:  prdata = nhigh_reg;
            default:        prdata = '0;
        endcase
    end

    // input request and tracking
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_track = !s_tuser[1];
    assign s_in     = $signed(s_tdata);
    assign bmin     = (s_tuser == ACT_RESTART) ? pivot_reg : min_reg;
    assign bmax     = (s_tuser == ACT_RESTART) ? pivot_reg : max_reg;
    assign tmin     = (s_in < bmin) ? s_in : bmin;
    assign tmax     = (s_in > bmax) ? s_in : bmax;

    // operand selection for scale and map back
    always_comb begin
        if (act_reg == ACT_FWD) begin
            lt       = samp_reg < pivot_reg;
            div_num  = lt ? dif33(pivot_reg, samp_reg) : dif33(samp_reg, pivot_reg);
            div_den  = lt ? dif33(pivot_reg, min_reg) : dif33(max_reg, pivot_reg);
            sel_diff = lt ? dif33(pnorm_reg, nlow_reg) : dif33(nhigh_reg, pnorm_reg);
            sel_base = pnorm_reg;
        end else begin
            lt       = samp_reg < pnorm_reg;
            div_num  = lt ? dif33(pnorm_reg, samp_reg) : dif33(samp_reg, pnorm_reg);
            div_den  = lt ? dif33(pnorm_reg, nlow_reg) : dif33(nhigh_reg, pnorm_reg);
            sel_diff = lt ? dif33(pivot_reg, min_reg) : dif33(max_reg, pivot_reg);
            sel_base = pivot_reg;
        end
    end

    assign div_start = (state_reg == ST_SETUP);
    assign mul_start = (accept && is_track && s_tlast) || (state_reg == ST_DIV && div_done);
    assign mul_d     = (state_reg == ST_IDLE) ? $signed({pivot_reg[DATA_W-1], pivot_reg})
                                              : diff_reg;
    assign mul_r     = (state_reg == ST_IDLE) ? pivot_reg : div_ratio;

    fpn_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .ratio   (div_ratio)
    );

    fpn_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .d       (mul_d),
        .r       (mul_r),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    // final sums
    assign exact  = sub_reg ? sext_w(base_reg) - sext_p(mul_prod)
                            : sext_w(base_reg) + sext_p(mul_prod);
    assign fix_hi = sext_w(pivot_reg) + sext_p(mul_prod) + sext_w(Q_ONE);
    assign fix_lo = sext_w(pivot_reg) - sext_p(mul_prod) - sext_w(Q_ONE);

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!is_track)    state_next = ST_SETUP;
                    else if (s_tlast) state_next = ST_MUL;
                    else              state_next = ST_OUT;
                end
            end
            ST_SETUP: state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_MUL;
            ST_MUL: begin
                if (mul_done) state_next = act_reg[1] ? ST_SUM : ST_FIX;
            end
            ST_SUM:   state_next = ST_OUT;
            ST_FIX:   state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            min_reg   <= -Q_ONE;
            max_reg   <= Q_ONE;
        end else begin
            state_reg <= state_next;
            if (accept && is_track) begin
                min_reg <= tmin;
                max_reg <= tmax;
            end
            // push degenerate extremes off the pivot
            if (state_reg == ST_FIX) begin
                if (max_reg == pivot_reg) max_reg <= sat32(fix_hi);
                if (min_reg == pivot_reg) min_reg <= sat32(fix_lo);
            end
        end
    end

    // request payload and result
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg   <= s_tuser;
            samp_reg  <= s_in;
            res_reg   <= '0;
            below_reg <= 1'b0;
            above_reg <= 1'b0;
        end
        if (state_reg == ST_SETUP) begin
            diff_reg <= sel_diff;
            base_reg <= sel_base;
            sub_reg  <= lt;
        end
        if (state_reg == ST_SUM) begin
            res_reg <= sat32(exact);
            if (act_reg == ACT_FWD) begin
                below_reg <= exact < sext_w(nlow_reg);
                above_reg <= !(exact < sext_w(nlow_reg)) && (exact > sext_w(nhigh_reg));
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_mapped_reg <= res_reg;
            m_below_reg  <= below_reg;
            m_above_reg  <= above_reg;
            m_low_reg    <= min_reg;
            m_high_reg   <= max_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_high_reg, m_low_reg, m_mapped_reg};
    assign m_tuser  = {m_above_reg, m_below_reg};

    // checks
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV) else $error("divider done outside divide step");

    a_mul_done_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == ST_MUL) else $error("multiplier done outside multiply step");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1])) else $error("both range flags set");

    a_plain_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_track && !s_tlast) |=> state_reg == ST_OUT)
        else $error("plain track request did not go to output");

endmodule

FILE: src/fpn_div.sv
// Bit-serial restoring divider: ratio = sat32(trunc(num * 2^16 / den)), or zero when den is zero.
// One quotient bit per cycle; uses fpn_pkg.
module fpn_div import fpn_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DIFF_W-1:0] num,
    input  logic signed [DIFF_W-1:0] den,
    output logic                     done,
    output logic signed [DATA_W-1:0] ratio
);

    logic                     busy_reg, fin_reg, done_reg;
    logic [QCNT_W-1:0]        cnt_reg;
    logic [QUO_W-1:0]         work_reg;
    logic [DIFF_W-1:0]        rem_reg, dmag_reg;
    logic                     neg_reg, zero_reg;
    logic signed [DATA_W-1:0] ratio_reg;

    logic [DIFF_W-1:0] nmag, dmag_in;
    logic [DIFF_W:0]   trial, trial_sub;
    logic              ge;
    logic              ov_pos, ov_neg;
    logic [DATA_W-1:0] qlow;

    assign nmag    = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
    assign dmag_in = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);

    // one restoring step
    assign trial     = {rem_reg, work_reg[QUO_W-1]};
    assign ge        = trial >= {1'b0, dmag_reg};
    assign trial_sub = trial - {1'b0, dmag_reg};

    // saturation of the unsigned quotient
    assign qlow   = work_reg[DATA_W-1:0];
    assign ov_pos = |work_reg[QUO_W-1:DATA_W-1];
    assign ov_neg = (|work_reg[QUO_W-1:DATA_W]) || (qlow[DATA_W-1] && (|qlow[DATA_W-2:0]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == QCNT_W'(QUO_W - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= {nmag, {FRAC_W{1'b0}}};
            rem_reg  <= '0;
            dmag_reg <= dmag_in;
            neg_reg  <= num[DIFF_W-1] ^ den[DIFF_W-1];
            zero_reg <= (den == '0);
        end else if (busy_reg) begin
            rem_reg  <= ge ? trial_sub[DIFF_W-1:0] : trial[DIFF_W-1:0];
            work_reg <= {work_reg[QUO_W-2:0], ge};
        end
        if (fin_reg) begin
            if (zero_reg) begin
                ratio_reg <= '0;
            end else if (!neg_reg) begin
                ratio_reg <= ov_pos ? SAT_MAX : $signed(qlow);
            end else begin
                ratio_reg <= ov_neg ? SAT_MIN : $signed(-qlow);
            end
        end
    end

    assign done  = done_reg;
    assign ratio = ratio_reg;

endmodule

FILE: src/fpn_mul.sv
// Bit-serial shift-add multiplier: prod = floor(d * r / 2^16).
// One multiplier bit per cycle; uses fpn_pkg.
module fpn_mul import fpn_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DIFF_W-1:0] d,
    input  logic signed [DATA_W-1:0] r,
    output logic                     done,
    output logic signed [PROD_W-1:0] prod
);

    logic                     busy_reg, fin_reg, done_reg;
    logic [MCNT_W-1:0]        cnt_reg;
    logic [DIFF_W-1:0]        dmag_reg, hi_reg;
    logic [DATA_W-1:0]        lo_reg;
    logic                     neg_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic [DIFF_W:0]             psum;
    logic [DIFF_W+DATA_W:0]      full_s;

    // add-and-shift step
    assign psum   = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, dmag_reg} : '0);
    // signed product; its top bits give the floored shift
    assign full_s = neg_reg ? -{1'b0, hi_reg, lo_reg} : {1'b0, hi_reg, lo_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MCNT_W'(DATA_W - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dmag_reg <= d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
            lo_reg   <= r[DATA_W-1] ? DATA_W'(-r) : DATA_W'(r);
            hi_reg   <= '0;
            neg_reg  <= d[DIFF_W-1] ^ r[DATA_W-1];
        end else if (busy_reg) begin
            hi_reg <= psum[DIFF_W:1];
            lo_reg <= {psum[0], lo_reg[DATA_W-1:1]};
        end
        if (fin_reg) begin
            prod_reg <= $signed(full_s[DIFF_W+DATA_W:FRAC_W]);
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule
